### src/qs_pkg.sv
// shared types and constants of the quicksort engine
`timescale 1ns / 1ps
`default_nettype none

package qs_pkg;

   // width of the value fields on both channels
   localparam int DATA_BITS = 32;

   // one input transfer
   typedef struct packed {
      logic signed [DATA_BITS-1:0] element_value;
      logic                        is_last;
   } req_type;

   // one result transfer
   typedef struct packed {
      logic signed [DATA_BITS-1:0] sorted_value;
      logic                        is_final;
      logic                        dropped;
   } rsp_type;

   // requests from the sort sequencer to the range stack
   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctrl_type;

   // status of the range stack
   typedef struct packed {
      logic empty;
   } stk_status_type;

endpackage

`default_nettype wire

### src/qs_range_stack.sv
// stack of pending (low, high) index ranges held in a synchronous memory
`timescale 1ns / 1ps
`default_nettype none

module qs_range_stack #(
   parameter int MAX_ELEMS = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire qs_pkg::stk_ctrl_type           ctrl,
   input  wire logic [$clog2(MAX_ELEMS)-1:0]   push_lo,
   input  wire logic [$clog2(MAX_ELEMS)-1:0]   push_hi,
   output      logic [$clog2(MAX_ELEMS)-1:0]   pop_lo,
   output      logic [$clog2(MAX_ELEMS)-1:0]   pop_hi,
   output      qs_pkg::stk_status_type         status
);
   import qs_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_ELEMS);
   localparam int DEP_BITS = $clog2(MAX_ELEMS + 1);

   logic [2*IDX_BITS-1:0] stack_mem_ff [MAX_ELEMS];
   logic [2*IDX_BITS-1:0] rd_data_ff;
   logic [DEP_BITS-1:0]   depth_ff;
   logic [DEP_BITS-1:0]   depth_in;
   logic                  full;
   logic                  do_push;
   logic                  do_pop;
   logic [IDX_BITS-1:0]   top_idx;

   // a push onto a full stack is ignored
   assign full    = (depth_ff == DEP_BITS'(MAX_ELEMS));
   assign do_push = ctrl.push && !full;
   assign do_pop  = ctrl.pop && (depth_ff != '0);
   assign top_idx = IDX_BITS'(depth_ff - DEP_BITS'(1));

   // depth counter
   always_comb begin
      depth_in = depth_ff;
      if (do_push) begin
         depth_in = depth_ff + DEP_BITS'(1);
      end else if (do_pop) begin
         depth_in = depth_ff - DEP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // stack memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_mem_ff[IDX_BITS'(depth_ff)] <= {push_lo, push_hi};
      end
      if (do_pop) begin
         rd_data_ff <= stack_mem_ff[top_idx];
      end
   end

   assign pop_lo       = rd_data_ff[2*IDX_BITS-1:IDX_BITS];
   assign pop_hi       = rd_data_ff[IDX_BITS-1:0];
   assign status.empty = (depth_ff == '0);

endmodule

`default_nettype wire

### src/qs_sort_core.sv
// element memory with load, partition and read-out sequencer
`timescale 1ns / 1ps
`default_nettype none

module qs_sort_core #(
   parameter int MAX_ELEMS  = 64,
   parameter int VALUE_BITS = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire qs_pkg::req_type in_data,
   output      logic            in_ready,
   input  wire logic            out_ready,
   output      logic            out_valid,
   output      qs_pkg::rsp_type out_data
);
   import qs_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_ELEMS);
   localparam int CNT_BITS = $clog2(MAX_ELEMS + 1);
   localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef enum logic [16:0] {
      ST_LOAD      = 17'h00001,
      ST_START     = 17'h00002,
      ST_POP       = 17'h00004,
      ST_RANGE     = 17'h00008,
      ST_PIVOT     = 17'h00010,
      ST_RSCAN_RD  = 17'h00020,
      ST_RSCAN_CHK = 17'h00040,
      ST_LSCAN_RD  = 17'h00080,
      ST_LSCAN_CHK = 17'h00100,
      ST_SWAP      = 17'h00200,
      ST_FIN_RD    = 17'h00400,
      ST_FIN_W1    = 17'h00800,
      ST_FIN_W2    = 17'h01000,
      ST_PUSH_HI   = 17'h02000,
      ST_PUSH_LO   = 17'h04000,
      ST_OUT_RD    = 17'h08000,
      ST_OUT_SEND  = 17'h10000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [IDX_BITS-1:0]   lo_ff, lo_in;
   logic [IDX_BITS-1:0]   hi_ff, hi_in;
   logic [IDX_BITS-1:0]   i_ff, i_in;
   logic [IDX_BITS-1:0]   j_ff, j_in;
   logic [IDX_BITS-1:0]   k_ff, k_in;
   logic [VALUE_BITS-1:0] pivot_ff, pivot_in;
   logic [VALUE_BITS-1:0] vi_ff, vi_in;
   logic [VALUE_BITS-1:0] vj_ff, vj_in;

   logic [VALUE_BITS-1:0] elem_mem_ff [MAX_ELEMS];
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [VALUE_BITS-1:0] wr_data;

   stk_ctrl_type          stk_ctrl;
   stk_status_type        stk_status;
   logic [IDX_BITS-1:0]   stk_push_lo;
   logic [IDX_BITS-1:0]   stk_push_hi;
   logic [IDX_BITS-1:0]   stk_pop_lo;
   logic [IDX_BITS-1:0]   stk_pop_hi;

   logic                  accept;
   logic                  mem_full;
   logic [VALUE_BITS-1:0] rd_key;
   logic [VALUE_BITS-1:0] pivot_key;
   logic                  last_out;

   qs_range_stack #(
      .MAX_ELEMS (MAX_ELEMS)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (stk_ctrl),
      .push_lo (stk_push_lo),
      .push_hi (stk_push_hi),
      .pop_lo  (stk_pop_lo),
      .pop_hi  (stk_pop_hi),
      .status  (stk_status)
   );

   assign in_ready  = (state_ff == ST_LOAD);
   assign accept    = in_valid && in_ready;
   assign mem_full  = (count_ff == CNT_BITS'(MAX_ELEMS));

   // order keys: flipping the sign bit makes unsigned order match signed order
   assign rd_key    = rd_data_ff ^ SIGN_BIT;
   assign pivot_key = pivot_ff ^ SIGN_BIT;
   assign last_out  = ((CNT_BITS'(k_ff) + CNT_BITS'(1)) == count_ff);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      pivot_in    = pivot_ff;
      vi_in       = vi_ff;
      vj_in       = vj_ff;
      rd_en       = 1'b0;
      rd_addr     = i_ff;
      wr_en       = 1'b0;
      wr_addr     = i_ff;
      wr_data     = vj_ff;
      stk_ctrl    = '0;
      stk_push_lo = '0;
      stk_push_hi = count_ff[IDX_BITS-1:0];
      case (state_ff)
         // collect values until the last one of the set
         ST_LOAD: begin
            if (accept) begin
               if (mem_full) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_BITS-1:0];
                  wr_data  = VALUE_BITS'($unsigned(in_data.element_value));
                  count_in = count_ff + CNT_BITS'(1);
               end
               if (in_data.is_last) begin
                  state_in = ST_START;
               end
            end
         end
         // whole set as the first range, if it has two or more values
         ST_START: begin
            stk_push_lo   = '0;
            stk_push_hi   = IDX_BITS'(count_ff - CNT_BITS'(1));
            stk_ctrl.push = (count_ff > CNT_BITS'(1));
            state_in      = ST_POP;
         end
         // next pending range, or read-out when none is left
         ST_POP: begin
            if (stk_status.empty) begin
               k_in     = '0;
               state_in = ST_OUT_RD;
            end else begin
               stk_ctrl.pop = 1'b1;
               state_in     = ST_RANGE;
            end
         end
         // range bounds arrive, fetch the pivot at its low end
         ST_RANGE: begin
            lo_in    = stk_pop_lo;
            hi_in    = stk_pop_hi;
            i_in     = stk_pop_lo;
            j_in     = stk_pop_hi;
            rd_en    = 1'b1;
            rd_addr  = stk_pop_lo;
            state_in = ST_PIVOT;
         end
         ST_PIVOT: begin
            pivot_in = rd_data_ff;
            state_in = ST_RSCAN_RD;
         end
         // right scan moves down past values not below the pivot
         ST_RSCAN_RD: begin
            if (i_ff != j_ff) begin
               rd_en    = 1'b1;
               rd_addr  = j_ff;
               state_in = ST_RSCAN_CHK;
            end else begin
               state_in = ST_FIN_RD;
            end
         end
         ST_RSCAN_CHK: begin
            vj_in = rd_data_ff;
            if (rd_key >= pivot_key) begin
               j_in     = j_ff - IDX_BITS'(1);
               state_in = ST_RSCAN_RD;
            end else begin
               state_in = ST_LSCAN_RD;
            end
         end
         // left scan moves up past values not above the pivot
         ST_LSCAN_RD: begin
            if (i_ff != j_ff) begin
               rd_en    = 1'b1;
               rd_addr  = i_ff;
               state_in = ST_LSCAN_CHK;
            end else begin
               state_in = ST_FIN_RD;
            end
         end
         ST_LSCAN_CHK: begin
            if (rd_key <= pivot_key) begin
               i_in     = i_ff + IDX_BITS'(1);
               state_in = ST_LSCAN_RD;
            end else begin
               // first half of the swap: right value into the left slot
               vi_in    = rd_data_ff;
               wr_en    = 1'b1;
               wr_addr  = i_ff;
               wr_data  = vj_ff;
               state_in = ST_SWAP;
            end
         end
         ST_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff;
            wr_data  = vi_ff;
            state_in = ST_RSCAN_RD;
         end
         // scans met: move the meeting value to the low end, pivot in place
         ST_FIN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            state_in = ST_FIN_W1;
         end
         ST_FIN_W1: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = rd_data_ff;
            state_in = ST_FIN_W2;
         end
         ST_FIN_W2: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff;
            wr_data  = pivot_ff;
            state_in = ST_PUSH_HI;
         end
         // upper part first, so the lower part is sorted next
         ST_PUSH_HI: begin
            stk_push_lo   = i_ff + IDX_BITS'(1);
            stk_push_hi   = hi_ff;
            stk_ctrl.push = (({1'b0, i_ff} + (IDX_BITS+1)'(1)) < {1'b0, hi_ff});
            state_in      = ST_PUSH_LO;
         end
         ST_PUSH_LO: begin
            stk_push_lo   = lo_ff;
            stk_push_hi   = i_ff - IDX_BITS'(1);
            stk_ctrl.push = (({1'b0, lo_ff} + (IDX_BITS+1)'(1)) < {1'b0, i_ff});
            state_in      = ST_POP;
         end
         // read-out in ascending order
         ST_OUT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (out_ready) begin
               if (last_out) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + IDX_BITS'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      pivot_ff <= pivot_in;
      vi_ff    <= vi_in;
      vj_ff    <= vj_in;
   end

   // element memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         elem_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= elem_mem_ff[rd_addr];
      end
   end

   assign out_valid             = (state_ff == ST_OUT_SEND);
   assign out_data.sorted_value = $signed(DATA_BITS'(rd_data_ff));
   assign out_data.is_final     = last_out;
   assign out_data.dropped      = ovf_ff;

endmodule

`default_nettype wire

### src/quicksort_engine.sv
// Quicksort engine: values are loaded one per transfer into an element memory
// of MAX_ELEMS entries; the transfer marked is_last starts an in-place sort
// (first element of each range as pivot, pending ranges on a stack memory),
// after which every stored value comes out in ascending signed order of
// VALUE_BITS bits, the final one flagged is_final. Values beyond capacity are
// discarded and reported through dropped on every result of that set. Loading
// takes values back to back. The sort runs on a single-port-read element
// memory: each element visit of a scan is a read followed by a compare and
// a swap is two writes; presorted input is the slowest case. Each result is
// read from the element memory and then sent. req_ready is high only while
// values are being loaded.
`timescale 1ns / 1ps
`default_nettype none

module quicksort_engine #(
   parameter int MAX_ELEMS  = 64,
   parameter int VALUE_BITS = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire qs_pkg::req_type req_data,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      qs_pkg::rsp_type rsp_data
);
   import qs_pkg::*;

   logic    core_valid;
   logic    core_ready;
   rsp_type core_data;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   qs_sort_core #(
      .MAX_ELEMS  (MAX_ELEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (req_ready),
      .out_ready (core_ready),
      .out_valid (core_valid),
      .out_data  (core_data)
   );

   // output register, refilled in the cycle its transfer completes
   assign core_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_ready) begin
         rsp_valid_in = core_valid;
         if (core_valid) begin
            rsp_data_in = core_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
